### design/ctls_pkg.sv
// Token scanner package: token record, scan modes, token kind codes,
// keyword tables and character helpers. No dependencies.
`timescale 1ns / 1ps
package ctls_pkg;

  localparam int unsigned MAX_LEXEME = 255;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_AW       = $clog2(Q_DEPTH);
  localparam int unsigned NUM_KW     = 13;
  localparam logic [23:0] LINE_TOP   = 24'hFFFFFF;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_ZERO, M_HEX, M_INT, M_REAL, M_IDENT
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] value;
    logic [7:0]  frac;
    logic [7:0]  ch;
    logic [23:0] line;
    logic [31:0] start;
    logic [7:0]  len;
    logic        last;
  } token_t;

  localparam logic [5:0] K_OTHER = 6'd0,  K_INT = 6'd1,  K_REAL = 6'd2, K_IDENT = 6'd3;
  localparam logic [5:0] K_ANDAND = 6'd14, K_AND = 6'd15, K_OROR = 6'd16, K_OR = 6'd17;
  localparam logic [5:0] K_EQEQ = 6'd18, K_EQ = 6'd19, K_NE = 6'd20, K_NOT = 6'd21;
  localparam logic [5:0] K_LE = 6'd22, K_LT = 6'd23, K_GE = 6'd24, K_GT = 6'd25;
  localparam logic [5:0] K_LPAR = 6'd26, K_RPAR = 6'd27, K_LBRC = 6'd28, K_RBRC = 6'd29;
  localparam logic [5:0] K_COMMA = 6'd30, K_SEMI = 6'd31, K_INC = 6'd32, K_ADDEQ = 6'd33;
  localparam logic [5:0] K_ADD = 6'd34, K_DEC = 6'd35, K_SUBEQ = 6'd36, K_ARROW = 6'd37;
  localparam logic [5:0] K_SUB = 6'd38, K_MULEQ = 6'd39, K_MUL = 6'd40, K_DIVEQ = 6'd41;
  localparam logic [5:0] K_DIV = 6'd42, K_MOD = 6'd43, K_DOT = 6'd44, K_LBRK = 6'd45;
  localparam logic [5:0] K_RBRK = 6'd46;
  localparam logic [5:0] K_NONE = 6'd0;

  // keyword text, first character in the top byte
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    {"if", 48'h0}, {"else", 32'h0}, {"while", 24'h0}, {"do", 48'h0},
    {"break", 24'h0}, {"true", 32'h0}, {"false", 24'h0}, {"int", 40'h0},
    {"bool", 32'h0}, {"char", 32'h0}, {"float", 24'h0}, {"return", 16'h0},
    {"struct", 16'h0}
  };
  localparam logic [7:0] KW_LEN [NUM_KW] = '{
    8'd2, 8'd4, 8'd5, 8'd2, 8'd5, 8'd4, 8'd5, 8'd3, 8'd4, 8'd4, 8'd5, 8'd6, 8'd6
  };
  localparam logic [5:0] KW_KIND [NUM_KW] = '{
    6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd11, 6'd11, 6'd11, 6'd12, 6'd13
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || is_digit(b)
           || (b == "_");
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (is_digit(b)) begin
        t = b - 8'h30;
        return {1'b1, t[3:0]};
      end else if ((b >= "a") && (b <= "f")) begin
        t = b - 8'h57;
        return {1'b1, t[3:0]};
      end else if ((b >= "A") && (b <= "F")) begin
        t = b - 8'h37;
        return {1'b1, t[3:0]};
      end
      return 5'd0;
    end
  endfunction

  function automatic logic [12:0] kw_narrow(input logic [12:0] cand, input logic [7:0] len,
                                            input logic [7:0] b);
    logic [12:0] c;
    begin
      c = cand;
      if (len >= 8'd8) return 13'd0;
      for (int k = 0; k < NUM_KW; k++) begin
        if (KW_TEXT[k][63 - 8*len[2:0] -: 8] != b) c[k] = 1'b0;
      end
      return c;
    end
  endfunction

  function automatic logic [5:0] single_op_kind(input logic [7:0] c);
    case (c)
      "&":     return K_AND;
      "|":     return K_OR;
      "=":     return K_EQ;
      "!":     return K_NOT;
      "<":     return K_LT;
      ">":     return K_GT;
      "+":     return K_ADD;
      "-":     return K_SUB;
      "*":     return K_MUL;
      default: return K_DIV;
    endcase
  endfunction

  function automatic logic [5:0] pair_op_kind(input logic [7:0] c, input logic [7:0] b);
    case (c)
      "&":     return (b == "&") ? K_ANDAND : K_NONE;
      "|":     return (b == "|") ? K_OROR : K_NONE;
      "=":     return (b == "=") ? K_EQEQ : K_NONE;
      "!":     return (b == "=") ? K_NE : K_NONE;
      "<":     return (b == "=") ? K_LE : K_NONE;
      ">":     return (b == "=") ? K_GE : K_NONE;
      "+":     return (b == "+") ? K_INC : ((b == "=") ? K_ADDEQ : K_NONE);
      "-":     return (b == "-") ? K_DEC : ((b == "=") ? K_SUBEQ :
                                            ((b == ">") ? K_ARROW : K_NONE));
      "*":     return (b == "=") ? K_MULEQ : K_NONE;
      "/":     return (b == "=") ? K_DIVEQ : K_NONE;
      default: return K_NONE;
    endcase
  endfunction

endpackage

### design/ctls_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on nothing.
`timescale 1ns / 1ps
interface ctls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface ctls_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] number_value;
  logic [7:0]  fraction_digits;
  logic [7:0]  token_char;
  logic [23:0] line_number;
  logic [31:0] start_offset;
  logic [7:0]  lexeme_length;
  logic        last_of_run;
  modport source (output valid, output token_kind, output number_value,
                  output fraction_digits, output token_char, output line_number,
                  output start_offset, output lexeme_length, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input number_value,
                input fraction_digits, input token_char, input line_number,
                input start_offset, input lexeme_length, input last_of_run,
                output ready);
endinterface

### design/ctls_front.sv
// Scanner front end: takes one byte a beat, holds scan state and forms
// up to two tokens per byte. Depends on ctls_pkg.
`timescale 1ns / 1ps
module ctls_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        b,
  output logic [1:0]        tok_n,
  output ctls_pkg::token_t  tok0,
  output ctls_pkg::token_t  tok1
);

  ctls_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  frac_r, frac_nxt;
  logic [12:0] kw_r, kw_nxt;
  logic [23:0] line_r, line_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] start_r, start_nxt;
  logic [7:0]  len_r, len_nxt;

  ctls_pkg::token_t ta, ti;
  logic ta_v, ti_v, taken;
  logic [4:0] hv;
  logic [7:0] len_grow;
  logic [31:0] acc_dec;
  logic [5:0] id_kind;

  always_comb begin
    hv       = ctls_pkg::hex_value(b);
    len_grow = (len_r < 8'(ctls_pkg::MAX_LEXEME)) ? len_r + 8'd1 : len_r;
    acc_dec  = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, 4'(b - 8'h30)};
    id_kind  = ctls_pkg::K_IDENT;
    for (int k = 0; k < ctls_pkg::NUM_KW; k++) begin
      if (kw_r[k] && (ctls_pkg::KW_LEN[k] == len_r)) id_kind = ctls_pkg::KW_KIND[k];
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    kw_nxt    = kw_r;
    line_nxt  = line_r;
    off_nxt   = off_r + 32'd1;
    start_nxt = start_r;
    len_nxt   = len_r;
    taken     = 1'b0;
    ta_v      = 1'b0;
    ti_v      = 1'b0;
    ta        = '0;
    ti        = '0;
    ta.line   = line_r;
    ta.start  = start_r;
    ta.len    = len_r;
    ti.line   = line_r;
    ti.start  = off_r;
    ti.len    = 8'd1;
    ti.ch     = b;

    case (mode_r)
      ctls_pkg::M_OP: begin
        if (ctls_pkg::pair_op_kind(pend_r, b) != ctls_pkg::K_NONE) begin
          ta_v     = 1'b1;
          ta.kind  = ctls_pkg::pair_op_kind(pend_r, b);
          ta.ch    = pend_r;
          ta.len   = 8'd2;
          mode_nxt = ctls_pkg::M_IDLE;
          taken    = 1'b1;
        end
      end
      ctls_pkg::M_ZERO: begin
        if ((b == "x") || (b == "X")) begin
          mode_nxt = ctls_pkg::M_HEX;
          len_nxt  = len_grow;
          taken    = 1'b1;
        end
      end
      ctls_pkg::M_HEX: begin
        if (hv[4]) begin
          acc_nxt = {acc_r[27:0], hv[3:0]};
          len_nxt = len_grow;
          taken   = 1'b1;
        end
      end
      ctls_pkg::M_INT: begin
        if (ctls_pkg::is_digit(b)) begin
          acc_nxt = acc_dec;
          len_nxt = len_grow;
          taken   = 1'b1;
        end else if (b == ".") begin
          mode_nxt = ctls_pkg::M_REAL;
          frac_nxt = 8'd0;
          len_nxt  = len_grow;
          taken    = 1'b1;
        end
      end
      ctls_pkg::M_REAL: begin
        if (ctls_pkg::is_digit(b)) begin
          acc_nxt  = acc_dec;
          frac_nxt = (frac_r != 8'hFF) ? frac_r + 8'd1 : frac_r;
          len_nxt  = len_grow;
          taken    = 1'b1;
        end
      end
      ctls_pkg::M_IDENT: begin
        if (ctls_pkg::is_word(b)) begin
          kw_nxt  = ctls_pkg::kw_narrow(kw_r, len_r, b);
          len_nxt = len_grow;
          taken   = 1'b1;
        end
      end
      default: mode_nxt = ctls_pkg::M_IDLE;
    endcase

    if (!taken) begin
      case (mode_r)
        ctls_pkg::M_OP: begin
          ta_v    = 1'b1;
          ta.kind = ctls_pkg::single_op_kind(pend_r);
          ta.ch   = pend_r;
        end
        ctls_pkg::M_ZERO, ctls_pkg::M_HEX, ctls_pkg::M_INT: begin
          ta_v     = 1'b1;
          ta.kind  = ctls_pkg::K_INT;
          ta.value = acc_r;
        end
        ctls_pkg::M_REAL: begin
          ta_v     = 1'b1;
          ta.kind  = ctls_pkg::K_REAL;
          ta.value = acc_r;
          ta.frac  = frac_r;
        end
        ctls_pkg::M_IDENT: begin
          ta_v    = 1'b1;
          ta.kind = id_kind;
        end
        default: ta_v = 1'b0;
      endcase
      mode_nxt = ctls_pkg::M_IDLE;

      case (b)
        " ", "\t": ti_v = 1'b0;
        "\n": line_nxt = (line_r != ctls_pkg::LINE_TOP) ? line_r + 24'd1 : line_r;
        "&", "|", "=", "!", "<", ">", "+", "-", "*", "/": begin
          pend_nxt  = b;
          mode_nxt  = ctls_pkg::M_OP;
          acc_nxt   = 32'd0;
          frac_nxt  = 8'd0;
          start_nxt = off_r;
          len_nxt   = 8'd1;
        end
        "(": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_LPAR;  end
        ")": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_RPAR;  end
        "{": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_LBRC;  end
        "}": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_RBRC;  end
        ",": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_COMMA; end
        ";": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_SEMI;  end
        "%": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_MOD;   end
        ".": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_DOT;   end
        "[": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_LBRK;  end
        "]": begin ti_v = 1'b1; ti.kind = ctls_pkg::K_RBRK;  end
        default: begin
          if (ctls_pkg::is_word(b)) begin
            frac_nxt  = 8'd0;
            start_nxt = off_r;
            len_nxt   = 8'd1;
            acc_nxt   = 32'd0;
            if (b == "0") begin
              mode_nxt = ctls_pkg::M_ZERO;
            end else if (ctls_pkg::is_digit(b)) begin
              mode_nxt = ctls_pkg::M_INT;
              acc_nxt  = {28'd0, 4'(b - 8'h30)};
            end else begin
              mode_nxt = ctls_pkg::M_IDENT;
              kw_nxt   = ctls_pkg::kw_narrow(13'h1FFF, 8'd0, b);
            end
          end else begin
            ti_v    = 1'b1;
            ti.kind = ctls_pkg::K_OTHER;
          end
        end
      endcase
    end

    // pack: earlier token first, last flag on the final one
    ti.last = 1'b1;
    ta.last = !ti_v;
    tok0    = ta_v ? ta : ti;
    tok1    = ti;
    tok_n   = {1'b0, ta_v} + {1'b0, ti_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ctls_pkg::M_IDLE;
      pend_r  <= 8'd0;
      acc_r   <= 32'd0;
      frac_r  <= 8'd0;
      kw_r    <= 13'h1FFF;
      line_r  <= 24'd1;
      off_r   <= 32'd0;
      start_r <= 32'd0;
      len_r   <= 8'd0;
    end else if (push) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      kw_r    <= kw_nxt;
      line_r  <= line_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

### design/ctls_queue.sv
// Token queue between scanner and output: takes up to two tokens a beat,
// gives one. Depends on ctls_pkg.
`timescale 1ns / 1ps
module ctls_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        push_n,
  input  ctls_pkg::token_t  tok0,
  input  ctls_pkg::token_t  tok1,
  output logic              space2,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ctls_pkg::token_t  head
);

  localparam int unsigned CW = ctls_pkg::Q_AW + 1;

  ctls_pkg::token_t mem [ctls_pkg::Q_DEPTH];
  logic [ctls_pkg::Q_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] add_n;
  logic pop;

  always_comb begin
    pop       = pop_valid && pop_ready;
    add_n     = push ? push_n : 2'd0;
    wr_nxt    = wr_r + ctls_pkg::Q_AW'(add_n);
    rd_nxt    = rd_r + ctls_pkg::Q_AW'(pop);
    cnt_nxt   = cnt_r + CW'(add_n) - CW'(pop);
    space2    = cnt_r <= CW'(ctls_pkg::Q_DEPTH - 2);
    pop_valid = cnt_r != '0;
    head      = mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (add_n != 2'd0) mem[wr_r] <= tok0;
    if (add_n == 2'd2) mem[wr_r + ctls_pkg::Q_AW'(1)] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/c_like_token_scanner_core.sv
// Byte-stream token scanner: source bytes in, tokens out through a four-entry
// queue. A token is written into the queue at the clock edge that accepts the
// byte that ends it. Throughput: one byte a cycle while the queue has room for
// two tokens; tokens drain at one token a cycle while the receiver is ready.
// Synchronous active-low reset clears scan state, line count to one, queue empty.
`timescale 1ns / 1ps
module c_like_token_scanner_core (
  input logic         clk,
  input logic         rst_n,
  ctls_in_if.sink     in_chan,
  ctls_out_if.source  out_chan
);

  logic [1:0] tok_n;
  ctls_pkg::token_t tok0, tok1, head;
  logic space2, push;

  assign in_chan.ready = space2;
  assign push = in_chan.valid && space2;

  ctls_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .b     (in_chan.source_byte),
    .tok_n (tok_n),
    .tok0  (tok0),
    .tok1  (tok1)
  );

  ctls_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_n    (tok_n),
    .tok0      (tok0),
    .tok1      (tok1),
    .space2    (space2),
    .pop_valid (out_chan.valid),
    .pop_ready (out_chan.ready),
    .head      (head)
  );

  assign out_chan.token_kind      = head.kind;
  assign out_chan.number_value    = head.value;
  assign out_chan.fraction_digits = head.frac;
  assign out_chan.token_char      = head.ch;
  assign out_chan.line_number     = head.line;
  assign out_chan.start_offset    = head.start;
  assign out_chan.lexeme_length   = head.len;
  assign out_chan.last_of_run     = head.last;

endmodule

### bench/c_like_token_scanner_core_tb.sv
// Self-checking bench for the byte-stream token scanner: drives source bytes
// with bursty valid, stalls the token side, and predicts every token.
// Depends on ctls_pkg, ctls_in_if / ctls_out_if and c_like_token_scanner_core.
`timescale 1ns / 1ps
module c_like_token_scanner_core_tb;
  import ctls_pkg::*;

  localparam logic [5:0] K_IF = 6'd4, K_ELSE = 6'd5, K_WHILE = 6'd6, K_DO = 6'd7;
  localparam logic [5:0] K_BREAK = 6'd8, K_TRUE = 6'd9, K_FALSE = 6'd10;
  localparam logic [5:0] K_BASIC = 6'd11, K_RETURN = 6'd12, K_STRUCT = 6'd13;

  logic clk;
  logic rst_n;

  ctls_in_if  in_chan ();
  ctls_out_if out_chan ();

  c_like_token_scanner_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  string      kw_word [13] = '{"if", "else", "while", "do", "break", "true", "false",
                               "int", "bool", "char", "float", "return", "struct"};
  logic [5:0] kw_code [13] = '{K_IF, K_ELSE, K_WHILE, K_DO, K_BREAK, K_TRUE, K_FALSE,
                               K_BASIC, K_BASIC, K_BASIC, K_BASIC, K_RETURN, K_STRUCT};

  // scanner state mirror
  mode_t       sc_mode;
  logic [7:0]  sc_op;
  logic [31:0] sc_acc;
  logic [7:0]  sc_frac;
  logic [12:0] sc_cand;
  logic [23:0] sc_line;
  logic [31:0] sc_offs;
  logic [31:0] sc_start;
  logic [7:0]  sc_len;

  token_t     token_q [$];
  logic [7:0] byte_q [$];

  int  errors = 0;
  int  checked = 0;
  int  sent = 0;
  int  drain_at = 0;
  bit  drained = 0;
  bit  run = 0;
  bit  in_fired = 0;
  int  burst = 1;
  int  gap = 0;
  int  cyc = 0;

  function automatic logic [5:0] op_alone(input logic [7:0] c);
    case (c)
      "&": return K_AND;
      "|": return K_OR;
      "=": return K_EQ;
      "!": return K_NOT;
      "<": return K_LT;
      ">": return K_GT;
      "+": return K_ADD;
      "-": return K_SUB;
      "*": return K_MUL;
      default: return K_DIV;
    endcase
  endfunction

  function automatic logic [5:0] op_joined(input logic [7:0] c, input logic [7:0] b);
    logic [5:0] k;
    k = K_NONE;
    case (c)
      "&": if (b == "&") k = K_ANDAND;
      "|": if (b == "|") k = K_OROR;
      "=": if (b == "=") k = K_EQEQ;
      "!": if (b == "=") k = K_NE;
      "<": if (b == "=") k = K_LE;
      ">": if (b == "=") k = K_GE;
      "+": if (b == "+") k = K_INC; else if (b == "=") k = K_ADDEQ;
      "-": if (b == "-") k = K_DEC; else if (b == "=") k = K_SUBEQ;
           else if (b == ">") k = K_ARROW;
      "*": if (b == "=") k = K_MULEQ;
      "/": if (b == "=") k = K_DIVEQ;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic bit digit_ch(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit alpha_ch(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic int hex_of(input logic [7:0] b);
    if (digit_ch(b)) return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic push_token(input logic [5:0] kind, input logic [31:0] val,
                            input logic [7:0] frac, input logic [7:0] ch,
                            input logic [31:0] start, input logic [7:0] len);
    token_t t;
    t.kind  = kind;
    t.value = val;
    t.frac  = frac;
    t.ch    = ch;
    t.line  = sc_line;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    token_q.push_back(t);
  endtask

  task automatic narrow_cand(input logic [7:0] b);
    logic [7:0] c;
    if (sc_len >= 8) begin
      sc_cand = '0;
      return;
    end
    for (int k = 0; k < 13; k++) begin
      c = (sc_len < kw_word[k].len()) ? kw_word[k][sc_len] : 8'd0;
      if (c != b) sc_cand[k] = 1'b0;
    end
  endtask

  task automatic grow;
    if (sc_len < MAX_LEXEME) sc_len++;
  endtask

  task automatic open_token(input mode_t m, input logic [31:0] acc);
    sc_mode  = m;
    sc_acc   = acc;
    sc_frac  = 0;
    sc_start = sc_offs;
    sc_len   = 1;
  endtask

  task automatic flush_pending;
    logic [5:0] kind;
    case (sc_mode)
      M_OP: push_token(op_alone(sc_op), 0, 0, sc_op, sc_start, sc_len);
      M_ZERO, M_HEX, M_INT: push_token(K_INT, sc_acc, 0, 0, sc_start, sc_len);
      M_REAL: push_token(K_REAL, sc_acc, sc_frac, 0, sc_start, sc_len);
      M_IDENT: begin
        kind = K_IDENT;
        for (int k = 0; k < 13; k++)
          if (sc_cand[k] && kw_word[k].len() == sc_len) kind = kw_code[k];
        push_token(kind, 0, 0, 0, sc_start, sc_len);
      end
      default: ;
    endcase
    sc_mode = M_IDLE;
  endtask

  task automatic scan_fresh(input logic [7:0] b);
    case (b)
      " ", "\t": return;
      "\n": begin
        if (sc_line != LINE_TOP) sc_line++;
        return;
      end
      "&", "|", "=", "!", "<", ">", "+", "-", "*", "/": begin
        sc_op = b;
        open_token(M_OP, 0);
        return;
      end
      "(": begin push_token(K_LPAR, 0, 0, b, sc_offs, 1); return; end
      ")": begin push_token(K_RPAR, 0, 0, b, sc_offs, 1); return; end
      "{": begin push_token(K_LBRC, 0, 0, b, sc_offs, 1); return; end
      "}": begin push_token(K_RBRC, 0, 0, b, sc_offs, 1); return; end
      ",": begin push_token(K_COMMA, 0, 0, b, sc_offs, 1); return; end
      ";": begin push_token(K_SEMI, 0, 0, b, sc_offs, 1); return; end
      "%": begin push_token(K_MOD, 0, 0, b, sc_offs, 1); return; end
      ".": begin push_token(K_DOT, 0, 0, b, sc_offs, 1); return; end
      "[": begin push_token(K_LBRK, 0, 0, b, sc_offs, 1); return; end
      "]": begin push_token(K_RBRK, 0, 0, b, sc_offs, 1); return; end
      default: ;
    endcase
    if (b == "0") open_token(M_ZERO, 0);
    else if (digit_ch(b)) open_token(M_INT, {24'd0, 8'(b - "0")});
    else if (alpha_ch(b) || b == "_") begin
      open_token(M_IDENT, 0);
      sc_cand = '1;
      sc_len  = 0;
      narrow_cand(b);
      sc_len  = 1;
    end else push_token(K_OTHER, 0, 0, b, sc_offs, 1);
  endtask

  task automatic scan_byte(input logic [7:0] b);
    int         n0;
    bit         taken;
    logic [5:0] k;
    int         h;
    n0    = token_q.size();
    taken = 0;
    case (sc_mode)
      M_OP: begin
        k = op_joined(sc_op, b);
        if (k != K_NONE) begin
          push_token(k, 0, 0, sc_op, sc_start, 2);
          sc_mode = M_IDLE;
          taken = 1;
        end
      end
      M_ZERO: if (b == "x" || b == "X") begin
        sc_mode = M_HEX;
        grow();
        taken = 1;
      end
      M_HEX: begin
        h = hex_of(b);
        if (h >= 0) begin
          sc_acc = sc_acc * 16 + 32'(h);
          grow();
          taken = 1;
        end
      end
      M_INT: begin
        if (digit_ch(b)) begin
          sc_acc = sc_acc * 10 + {24'd0, 8'(b - "0")};
          grow();
          taken = 1;
        end else if (b == ".") begin
          sc_mode = M_REAL;
          sc_frac = 0;
          grow();
          taken = 1;
        end
      end
      M_REAL: if (digit_ch(b)) begin
        sc_acc = sc_acc * 10 + {24'd0, 8'(b - "0")};
        if (sc_frac != 8'hFF) sc_frac++;
        grow();
        taken = 1;
      end
      M_IDENT: if (alpha_ch(b) || digit_ch(b) || b == "_") begin
        narrow_cand(b);
        grow();
        taken = 1;
      end
      default: sc_mode = M_IDLE;
    endcase
    if (!taken) begin
      flush_pending();
      scan_fresh(b);
    end
    sc_offs++;
    if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int n, input bit hex);
    string hx = "0123456789abcdefABCDEF";
    for (int i = 0; i < n; i++)
      byte_q.push_back(hex ? hx[$urandom_range(0, 21)] : 8'(8'("0") + $urandom_range(0, 9)));
  endtask

  task automatic add_word(input int n);
    string wc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    byte_q.push_back(wc[$urandom_range(0, 52)]);
    for (int i = 1; i < n; i++) byte_q.push_back(wc[$urandom_range(0, 62)]);
  endtask

  task automatic add_fragment;
    string ops [] = '{"&&", "&", "||", "|", "==", "=", "!=", "!", "<=", "<", ">=", ">",
                      "++", "+=", "+", "--", "-=", "->", "-", "*=", "*", "/=", "/",
                      "(", ")", "{", "}", ",", ";", "%", ".", "[", "]"};
    string gaps [] = '{" ", "\t", "\n", "  ", ""};
    case ($urandom_range(0, 11))
      0, 1: add_text(kw_word[$urandom_range(0, 12)]);
      2, 3: add_word($urandom_range(1, 10));
      4:    add_digits($urandom_range(1, 12), 0);
      5: begin add_text($urandom_range(0, 1) ? "0x" : "0X"); add_digits($urandom_range(0, 10), 1); end
      6: begin add_digits($urandom_range(1, 6), 0); add_text("."); add_digits($urandom_range(0, 8), 0); end
      7, 8: add_text(ops[$urandom_range(0, ops.size() - 1)]);
      9:  byte_q.push_back(8'($urandom_range(0, 255)));
      10: add_text($urandom_range(0, 1) ? "0" : "0x");
      default: add_text(ops[$urandom_range(0, 22)]);
    endcase
    add_text(gaps[$urandom_range(0, gaps.size() - 1)]);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      scan_byte(in_chan.source_byte);
      in_fired = 1;
    end
  end

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.token_kind, out_chan.number_value, out_chan.fraction_digits,
              out_chan.token_char, out_chan.line_number, out_chan.start_offset,
              out_chan.lexeme_length, out_chan.last_of_run};
      checked++;
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token %p", got);
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("token mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // sender: bursts with gaps, one pause for a full drain
  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nb;
    nv = in_chan.valid;
    nb = in_chan.source_byte;
    if (rst_n && (!in_chan.valid || in_fired)) begin
      nv = 1'b0;
      in_fired = 0;
      if (!drained && sent == drain_at && drain_at > 0) begin
        if (token_q.size() == 0) drained = 1;
      end else if (gap > 0) gap--;
      else if (run && byte_q.size() > 0) begin
        nv = 1'b1;
        nb = byte_q.pop_front();
        sent++;
        burst--;
        if (burst <= 0) begin
          burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
          gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_chan.valid       <= nv;
    in_chan.source_byte <= nb;
  end

  // receiver: phases of no stall, random stall and heavy stall
  always @(negedge clk) begin
    case ((cyc / 150) % 3)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= 1'($urandom_range(0, 1));
      default: out_chan.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    string long_id;
    in_chan.valid       = 1'b0;
    in_chan.source_byte = 8'd0;
    out_chan.ready      = 1'b0;
    rst_n    = 1'b0;
    sc_mode  = M_IDLE;
    sc_op    = 0;
    sc_acc   = 0;
    sc_frac  = 0;
    sc_cand  = '1;
    sc_line  = 1;
    sc_offs  = 0;
    sc_start = 0;
    sc_len   = 0;

    add_text("if else while do break true false int bool char float return struct ");
    add_text("iff _x9\n&& & || | == = != ! <= < >= > ( ) { } , ; ++ += + -- -= -> - ");
    add_text("*= * /= / % . [ ]\t012 0.5 0x 0XffFFffFF1 12. 3.14159 99999999999\n");
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h80);
    byte_q.push_back(8'h00);
    long_id = "";
    for (int i = 0; i < 40; i++) long_id = {long_id, "abcdefg"};
    add_text({long_id, " 1."});
    add_digits(300, 0);
    add_text(" 0x");
    add_digits(270, 1);
    byte_q.push_back(8'h00);
    drain_at = byte_q.size();
    while (byte_q.size() < 1500) add_fragment();
    byte_q.push_back(8'h00);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run = 1;
    while (byte_q.size() > 0 || in_chan.valid) @(posedge clk);
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("scanned %0d bytes, checked %0d tokens, %0d mismatches", sent, checked, errors);
    $display("covered keywords, all operators, numbers, reals, end marks and long lexemes");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### c_like_token_scanner_core.f
design/ctls_pkg.sv
design/ctls_if.sv
design/ctls_front.sv
design/ctls_queue.sv
design/c_like_token_scanner_core.sv
bench/c_like_token_scanner_core_tb.sv
